### src/dlps_pkg.sv
// ----------------------------------------------------------------------------
// dlps_pkg: shared types and constants of the DDA line pixel stepper
// Command codes, field widths, register indexes and the pixel record passed
// from the line tracker to the output stage.
// ----------------------------------------------------------------------------
package dlps_pkg;

  // Coordinate and surface widths
  localparam int COORD_BITS = 8;
  localparam int DIM_BITS   = 9;
  localparam int ADDR_BITS  = 16;
  localparam int GLYPH_BITS = 8;
  localparam int CFG_IDX_BITS = 1;

  // Reset values of the surface registers
  localparam logic [DIM_BITS-1:0] SURFACE_WIDTH_RST  = DIM_BITS'(80);
  localparam logic [DIM_BITS-1:0] SURFACE_HEIGHT_RST = DIM_BITS'(24);

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_SURFACE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SURFACE_HEIGHT = 1'b1;

  // Input commands
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

  // One pixel after position, clipping and end-of-line evaluation
  typedef struct packed {
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [GLYPH_BITS-1:0] glyph;
    logic                  on_surface;
    logic                  active;
    logic                  last;
  } pixel_t;

endpackage

### src/dlps_axis.sv
// ----------------------------------------------------------------------------
// dlps_axis: one axis of the DDA stepper
// Rounds the exact quotient/remainder offset to a coordinate and computes the
// accumulator values for the next pixel.
// ----------------------------------------------------------------------------
module dlps_axis
  import dlps_pkg::*;
(
  input  logic [COORD_BITS-1:0] origin,
  input  logic                  negative,
  input  logic [COORD_BITS-1:0] span,
  input  logic [COORD_BITS-1:0] total,
  input  logic [COORD_BITS-1:0] quot,
  input  logic [COORD_BITS-1:0] rem,
  output logic [COORD_BITS-1:0] pos,
  output logic [COORD_BITS-1:0] quot_nxt,
  output logic [COORD_BITS-1:0] rem_nxt
);

  logic                  round_up;
  logic [COORD_BITS-1:0] offset;
  logic [COORD_BITS:0]   rem_sum;

  // Round half away from zero: bump when 2*rem >= total
  always_comb begin
    round_up = (total != '0) && ({rem, 1'b0} >= {1'b0, total});
    offset   = quot + COORD_BITS'(round_up);
    pos      = negative ? (origin - offset) : (origin + offset);
  end

  // Accumulator advance: one add and one compare
  always_comb begin
    rem_sum = {1'b0, rem} + {1'b0, span};
    if (rem_sum >= {1'b0, total}) begin
      rem_nxt  = COORD_BITS'(rem_sum - {1'b0, total});
      quot_nxt = quot + COORD_BITS'(1);
    end else begin
      rem_nxt  = rem_sum[COORD_BITS-1:0];
      quot_nxt = quot;
    end
  end

endmodule

### src/dlps_tracker.sv
// ----------------------------------------------------------------------------
// dlps_tracker: line state and pixel stage
// Holds the loaded line, takes load and step transfers, and registers one
// pixel record per step transfer.
// ----------------------------------------------------------------------------
module dlps_tracker
  import dlps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_command,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [COORD_BITS-1:0] in_end_x,
  input  logic [COORD_BITS-1:0] in_end_y,
  input  logic [GLYPH_BITS-1:0] in_glyph,
  input  logic [DIM_BITS-1:0]   surface_width,
  input  logic [DIM_BITS-1:0]   surface_height,
  input  logic                  pix_ready,
  output logic                  pix_valid,
  output pixel_t                pix
);

  // Line state
  logic [COORD_BITS-1:0] origin_x_r, origin_y_r;
  logic                  negative_x_r, negative_y_r;
  logic [COORD_BITS-1:0] span_x_r, span_y_r;
  logic [COORD_BITS-1:0] step_total_r, step_index_r;
  logic [COORD_BITS-1:0] quot_x_r, rem_x_r, quot_y_r, rem_y_r;
  logic [GLYPH_BITS-1:0] stored_glyph_r;
  logic                  busy_r;

  // Pixel stage
  logic   pix_valid_r;
  pixel_t pix_r;

  logic                  stage_ready;
  logic                  accept;
  logic                  is_step;
  logic [COORD_BITS-1:0] px, py;
  logic [COORD_BITS-1:0] quot_x_nxt, rem_x_nxt, quot_y_nxt, rem_y_nxt;
  logic                  neg_x, neg_y;
  logic [COORD_BITS-1:0] span_x, span_y;
  logic                  last;
  pixel_t                pix_nxt;

  // Handshake: the pixel stage frees up when empty or moving downstream
  assign stage_ready = !pix_valid_r || pix_ready;
  assign in_stall    = !stage_ready;
  assign accept      = in_valid && stage_ready;
  assign is_step     = (cmd_t'(in_command) == CMD_STEP);

  dlps_axis u_axis_x (
    .origin   (origin_x_r),
    .negative (negative_x_r),
    .span     (span_x_r),
    .total    (step_total_r),
    .quot     (quot_x_r),
    .rem      (rem_x_r),
    .pos      (px),
    .quot_nxt (quot_x_nxt),
    .rem_nxt  (rem_x_nxt)
  );

  dlps_axis u_axis_y (
    .origin   (origin_y_r),
    .negative (negative_y_r),
    .span     (span_y_r),
    .total    (step_total_r),
    .quot     (quot_y_r),
    .rem      (rem_y_r),
    .pos      (py),
    .quot_nxt (quot_y_nxt),
    .rem_nxt  (rem_y_nxt)
  );

  // Load decode: direction and span per axis
  always_comb begin
    neg_x  = (in_end_x < in_start_x);
    neg_y  = (in_end_y < in_start_y);
    span_x = neg_x ? (in_start_x - in_end_x) : (in_end_x - in_start_x);
    span_y = neg_y ? (in_start_y - in_end_y) : (in_end_y - in_start_y);
  end

  // Pixel record for a step transfer; idle steps give an all-zero record
  always_comb begin
    last    = (step_index_r >= step_total_r);
    pix_nxt = '0;
    if (busy_r) begin
      pix_nxt.px         = px;
      pix_nxt.py         = py;
      pix_nxt.glyph      = stored_glyph_r;
      pix_nxt.on_surface = ({1'b0, px} < surface_width) &&
                           ({1'b0, py} < surface_height);
      pix_nxt.active     = 1'b1;
      pix_nxt.last       = last;
    end
  end

  // Line state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r     <= '0;
      origin_y_r     <= '0;
      negative_x_r   <= 1'b0;
      negative_y_r   <= 1'b0;
      span_x_r       <= '0;
      span_y_r       <= '0;
      step_total_r   <= '0;
      step_index_r   <= '0;
      quot_x_r       <= '0;
      rem_x_r        <= '0;
      quot_y_r       <= '0;
      rem_y_r        <= '0;
      stored_glyph_r <= '0;
      busy_r         <= 1'b0;
    end else if (accept) begin
      if (!is_step) begin
        origin_x_r     <= in_start_x;
        origin_y_r     <= in_start_y;
        negative_x_r   <= neg_x;
        negative_y_r   <= neg_y;
        span_x_r       <= span_x;
        span_y_r       <= span_y;
        step_total_r   <= (span_x > span_y) ? span_x : span_y;
        step_index_r   <= '0;
        quot_x_r       <= '0;
        rem_x_r        <= '0;
        quot_y_r       <= '0;
        rem_y_r        <= '0;
        stored_glyph_r <= in_glyph;
        busy_r         <= 1'b1;
      end else if (busy_r) begin
        if (last) begin
          busy_r <= 1'b0;
        end else begin
          step_index_r <= step_index_r + COORD_BITS'(1);
          quot_x_r     <= quot_x_nxt;
          rem_x_r      <= rem_x_nxt;
          quot_y_r     <= quot_y_nxt;
          rem_y_r      <= rem_y_nxt;
        end
      end
    end
  end

  // Pixel stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_valid_r <= 1'b0;
    end else if (stage_ready) begin
      pix_valid_r <= accept && is_step;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready && accept && is_step) begin
      pix_r <= pix_nxt;
    end
  end

  assign pix_valid = pix_valid_r;
  assign pix       = pix_r;

endmodule

### src/dlps_emit.sv
// ----------------------------------------------------------------------------
// dlps_emit: address stage and result register
// Forms the row-major write address of a clipped pixel and holds the result
// until the downstream side takes it.
// ----------------------------------------------------------------------------
module dlps_emit
  import dlps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  pix_valid,
  output logic                  pix_ready,
  input  pixel_t                pix,
  input  logic [DIM_BITS-1:0]   surface_width,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DIM_BITS-1:0]   out_pixel_x,
  output logic [DIM_BITS-1:0]   out_pixel_y,
  output logic [ADDR_BITS-1:0]  out_write_address,
  output logic [GLYPH_BITS-1:0] out_pixel_glyph,
  output logic                  out_write_enable,
  output logic                  out_line_active,
  output logic                  out_last_pixel
);

  logic                  out_valid_r;
  logic [DIM_BITS-1:0]   pixel_x_r, pixel_y_r;
  logic [ADDR_BITS-1:0]  write_address_r;
  logic [GLYPH_BITS-1:0] pixel_glyph_r;
  logic                  write_enable_r, line_active_r, last_pixel_r;

  logic [COORD_BITS+DIM_BITS-1:0] row_base;
  logic [ADDR_BITS-1:0]           addr_nxt;

  assign pix_ready = !out_valid_r || !out_stall;

  // Row-major address, zero when clipped
  always_comb begin
    row_base = pix.py * surface_width;
    addr_nxt = pix.on_surface ? (row_base[ADDR_BITS-1:0] + ADDR_BITS'(pix.px)) : '0;
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pix_ready) begin
      out_valid_r <= pix_valid;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pix_ready && pix_valid) begin
      pixel_x_r       <= DIM_BITS'(pix.px);
      pixel_y_r       <= DIM_BITS'(pix.py);
      write_address_r <= addr_nxt;
      pixel_glyph_r   <= pix.glyph;
      write_enable_r  <= pix.on_surface;
      line_active_r   <= pix.active;
      last_pixel_r    <= pix.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_x       = pixel_x_r;
  assign out_pixel_y       = pixel_y_r;
  assign out_write_address = write_address_r;
  assign out_pixel_glyph   = pixel_glyph_r;
  assign out_write_enable  = write_enable_r;
  assign out_line_active   = line_active_r;
  assign out_last_pixel    = last_pixel_r;

endmodule

### src/dda_line_pixel_stepper_core.sv
// Result path: a step transfer passes through the pixel stage, then the address
// stage into the result register; a load transfer gives no result.
// Throughput: one transfer per cycle, set by the single add and compare per
// axis that advances the accumulators; stalls back up through both stages.
// Reset (rst_n low, synchronous): line goes idle, pipeline empties, surface
// becomes 80 x 24.
// ----------------------------------------------------------------------------
// dda_line_pixel_stepper_core: DDA line pixel stepper, top level
// Surface configuration registers, line tracker and output stage.
// ----------------------------------------------------------------------------
module dda_line_pixel_stepper_core
  import dlps_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [DIM_BITS-1:0]     cfg_wdata,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_command,
  input  logic [COORD_BITS-1:0]   in_start_x,
  input  logic [COORD_BITS-1:0]   in_start_y,
  input  logic [COORD_BITS-1:0]   in_end_x,
  input  logic [COORD_BITS-1:0]   in_end_y,
  input  logic [GLYPH_BITS-1:0]   in_glyph,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [DIM_BITS-1:0]     out_pixel_x,
  output logic [DIM_BITS-1:0]     out_pixel_y,
  output logic [ADDR_BITS-1:0]    out_write_address,
  output logic [GLYPH_BITS-1:0]   out_pixel_glyph,
  output logic                    out_write_enable,
  output logic                    out_line_active,
  output logic                    out_last_pixel
);

  logic [DIM_BITS-1:0] surface_width_r, surface_height_r;
  logic                pix_valid, pix_ready;
  pixel_t              pix;

  // Surface registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      surface_width_r  <= SURFACE_WIDTH_RST;
      surface_height_r <= SURFACE_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SURFACE_WIDTH:  surface_width_r  <= cfg_wdata;
        REG_SURFACE_HEIGHT: surface_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dlps_tracker u_tracker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .in_glyph       (in_glyph),
    .surface_width  (surface_width_r),
    .surface_height (surface_height_r),
    .pix_ready      (pix_ready),
    .pix_valid      (pix_valid),
    .pix            (pix)
  );

  dlps_emit u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .pix_valid         (pix_valid),
    .pix_ready         (pix_ready),
    .pix               (pix),
    .surface_width     (surface_width_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_write_address (out_write_address),
    .out_pixel_glyph   (out_pixel_glyph),
    .out_write_enable  (out_write_enable),
    .out_line_active   (out_line_active),
    .out_last_pixel    (out_last_pixel)
  );

endmodule
